### rtl/bloom_filter_hit_rate_macros.svh
// ----------------------------------------------------------------------------
// Bloom filter hit-rate monitor: assertion macros
// Assertions are compiled in simulation only and are empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_HIT_RATE_MACROS_SVH
`define BLOOM_FILTER_HIT_RATE_MACROS_SVH
`ifndef SYNTHESIS
`define BF_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BF_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BF_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define BF_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

### rtl/bfhr_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter hit-rate monitor: package
// Shared types, constants and request codes.
// ----------------------------------------------------------------------------
package bfhr_pkg;

    localparam int CELLS_DEF      = 65536;
    localparam int WINDOW_DEF     = 16;
    localparam int MAX_HASHES_DEF = 7;

    localparam logic [63:0] MIX_MUL = 64'h45d9f3b;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_PROBE  = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        REG_HASH_COUNT = 3'd0,
        REG_CELL_COUNT = 3'd1,
        REG_SEED_A     = 3'd2,
        REG_SEED_B     = 3'd3,
        REG_WINDOW_LEN = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [63:0] key;
    } bf_in_t;

    typedef struct packed {
        logic        hit;
        logic [16:0] hit_rate;
        logic [35:0] window_hits;
        logic [35:0] window_probes;
    } bf_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HLOAD,
        ST_HMUL1,
        ST_HMUL2,
        ST_HFIN,
        ST_MOD,
        ST_MEMRD,
        ST_MEMWAIT,
        ST_MEMCHK,
        ST_RINGRD,
        ST_RINGWAIT,
        ST_RINGUPD,
        ST_DIV,
        ST_DONE,
        ST_CLEAR
    } state_t;

    // Shared datapath operation select
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_XLOAD,
        OP_MIXLO,
        OP_MIXHI,
        OP_FIN,
        OP_MODSTEP,
        OP_DIVSTEP
    } op_t;

endpackage

### rtl/bfhr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bfhr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/bfhr_alu.sv
// ----------------------------------------------------------------------------
// Bloom filter hit-rate monitor: shared arithmetic unit
// Two work registers (acc, quo); split mix multiply, restoring mod and divide steps.
// ----------------------------------------------------------------------------
module bfhr_alu (
    input  logic              clk,
    input  bfhr_pkg::op_t     op,
    input  logic [63:0]       load_val,
    input  logic [63:0]       divisor,
    output logic [63:0]       acc,
    output logic [63:0]       quo
);
    import bfhr_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] mixed;
    logic [64:0] trial;
    logic [63:0] shl;
    logic [31:0] mul_a;
    logic [58:0] prod;

    assign mixed = {{16{acc_reg[63]}}, acc_reg[63:16]} ^ acc_reg;
    // one 32 x 27 multiplier: low half of the mixed word, then its high half
    assign mul_a = (op == OP_MIXHI) ? quo_reg[63:32] : mixed[31:0];
    assign prod  = mul_a * MIX_MUL[26:0];
    // restoring step: remainder in acc, dividend bits shifted out of quo
    assign shl   = {acc_reg[62:0], quo_reg[63]};
    assign trial = {acc_reg[63], shl} - {1'b0, divisor};

    always_comb
    begin
        acc_next = acc_reg;
        quo_next = quo_reg;
        case (op) inside
            OP_LOAD:
            begin
                acc_next = 64'd0;
                quo_next = load_val;
            end
            OP_XLOAD:   acc_next = load_val;
            OP_MIXLO:
            begin
                quo_next = mixed;
                acc_next = {5'd0, prod};
            end
            // high partial product only reaches the top 32 bits mod 2^64
            OP_MIXHI:   acc_next = acc_reg + {prod[31:0], 32'd0};
            OP_FIN:
            begin
                quo_next = {mixed[31:0], 32'd0};
                acc_next = 64'd0;
            end
            OP_MODSTEP, OP_DIVSTEP:
            begin
                if (!trial[64])
                begin
                    acc_next = trial[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    acc_next = shl;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
    end

    assign acc = acc_reg;
    assign quo = quo_reg;
endmodule

### rtl/bloom_filter_hit_rate.sv
// ----------------------------------------------------------------------------
// Bloom filter hit-rate monitor
// Seeded-hash Bloom filter with a windowed hit/probe ratio in Q1.16.
// ----------------------------------------------------------------------------
// Channel   Signals                         Direction  Transfer when
// request   start, busy, req                in         start && !busy
// result    done, rsp                       out        done (one cycle)
// config    cfg_we, cfg_index, cfg_data     in         cfg_we
//
// Insert/probe: per hash 1 load, 4 mix, 1 fold, 32 mod steps and a memory
// read, wait and check, up to 7 hashes (a probe stops at the first clear bit),
// then the divide steps and a result state, all on the one shared unit.
// Tick: ring read, wait and update, then divide and result. Clear: WINDOW
// sweep, then divide and result. After reset the filter is swept clear,
// one bit a cycle, ring alongside; a window_len write sweeps the ring.
// Busy high throughout. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
`include "bloom_filter_hit_rate_macros.svh"
module bloom_filter_hit_rate #(
    parameter int CELLS      = bfhr_pkg::CELLS_DEF,
    parameter int WINDOW     = bfhr_pkg::WINDOW_DEF,
    parameter int MAX_HASHES = bfhr_pkg::MAX_HASHES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bfhr_pkg::bf_in_t  req,
    output logic              done,
    output bfhr_pkg::bf_out_t rsp,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import bfhr_pkg::*;

    localparam int CW = $clog2(CELLS);
    localparam int WW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WD = (WINDOW > 1) ? WINDOW : 2;
    localparam int CCW = $clog2(CELLS + 1);
    localparam int LW = $clog2(WINDOW + 1);
    localparam int HW = $clog2(MAX_HASHES + 1);

    // ---------------- configuration ----------------
    logic [2:0]  hash_count_reg;
    logic [16:0] cell_count_reg;
    logic [63:0] seed_a_reg;
    logic [47:0] seed_b_reg;
    logic [4:0]  window_len_reg;
    logic        win_restart;

    assign win_restart = cfg_we && (cfg_index == REG_WINDOW_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg <= 3'd7;
            cell_count_reg <= 17'd65536;
            seed_a_reg     <= 64'd0;
            seed_b_reg     <= 48'd0;
            window_len_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HASH_COUNT: hash_count_reg <= cfg_data[2:0];
                REG_CELL_COUNT: cell_count_reg <= cfg_data[16:0];
                REG_SEED_A:     seed_a_reg     <= cfg_data;
                REG_SEED_B:     seed_b_reg     <= cfg_data[47:0];
                REG_WINDOW_LEN: window_len_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // effective values
    logic [HW-1:0]  eff_hashes;
    logic [CCW-1:0] eff_cells;
    logic [LW-1:0]  eff_win, eff_win_cfg;

    always_comb
    begin
        eff_hashes = ({29'd0, hash_count_reg} > MAX_HASHES) ? HW'(MAX_HASHES)
                                                              : HW'(hash_count_reg);
        if (cell_count_reg == 17'd0)
            eff_cells = CCW'(1);
        else if ({15'd0, cell_count_reg} > CELLS)
            eff_cells = CCW'(CELLS);
        else
            eff_cells = CCW'(cell_count_reg);
        if (window_len_reg == 5'd0)
            eff_win = LW'(1);
        else if ({27'd0, window_len_reg} > WINDOW)
            eff_win = LW'(WINDOW);
        else
            eff_win = LW'(window_len_reg);
        // value being written now, for the restart
        if (cfg_data[4:0] == 5'd0)
            eff_win_cfg = LW'(1);
        else if ({27'd0, cfg_data[4:0]} > WINDOW)
            eff_win_cfg = LW'(WINDOW);
        else
            eff_win_cfg = LW'(cfg_data[4:0]);
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;
    req_t   req_reg;
    logic [31:0] key_reg;
    logic [2:0]  hidx_reg;
    logic [6:0]  step_reg;
    logic [CW:0] sweep_reg;
    logic        boot_reg;
    logic [31:0] cur_hits_reg, cur_probes_reg;
    logic [35:0] sum_hits_reg, sum_probes_reg;
    logic [WW-1:0] slot_reg;
    logic          hit_reg;

    // ---------------- shared unit ----------------
    op_t         op;
    logic [63:0] load_val, divisor, acc, quo;
    logic [15:0] seed;

    always_comb
    begin
        case (hidx_reg)
            3'd0:    seed = seed_a_reg[15:0];
            3'd1:    seed = seed_a_reg[31:16];
            3'd2:    seed = seed_a_reg[47:32];
            3'd3:    seed = seed_a_reg[63:48];
            3'd4:    seed = seed_b_reg[15:0];
            3'd5:    seed = seed_b_reg[31:16];
            3'd6:    seed = seed_b_reg[47:32];
            default: seed = 16'd0;
        endcase
    end

    bfhr_alu u_alu (
        .clk      (clk),
        .op       (op),
        .load_val (load_val),
        .divisor  (divisor),
        .acc      (acc),
        .quo      (quo)
    );

    // ---------------- memories ----------------
    logic          fm_we, fm_wd, fm_rd;
    logic [CW-1:0] fm_wa, fm_ra;
    logic          rg_we;
    logic [WW-1:0] rg_wa, rg_ra;
    logic [31:0]   rh_wd, rp_wd, rh_rd, rp_rd;

    bfhr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_filter (
        .clk(clk), .we(fm_we), .waddr(fm_wa), .wdata(fm_wd),
        .raddr(fm_ra), .rdata(fm_rd)
    );
    bfhr_ram #(.WIDTH(32), .DEPTH(WD)) u_ring_hits (
        .clk(clk), .we(rg_we), .waddr(rg_wa), .wdata(rh_wd),
        .raddr(rg_ra), .rdata(rh_rd)
    );
    bfhr_ram #(.WIDTH(32), .DEPTH(WD)) u_ring_probes (
        .clk(clk), .we(rg_we), .waddr(rg_wa), .wdata(rp_wd),
        .raddr(rg_ra), .rdata(rp_rd)
    );

    // ---------------- next state ----------------
    logic sweep_end;
    assign sweep_end = boot_reg ? (sweep_reg == (CW+1)'(CELLS - 1))
                                : (sweep_reg == (CW+1)'(WD - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (win_restart)
                    state_next = ST_CLEAR;
                else if (start)
                begin
                    unique case (req.req_type) inside
                        REQ_INSERT, REQ_PROBE:
                            state_next = (eff_hashes == '0) ? ST_DIV : ST_HLOAD;
                        REQ_TICK:  state_next = ST_RINGRD;
                        default:   state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_HLOAD:    state_next = ST_HMUL1;
            ST_HMUL1:    state_next = ST_HMUL2;
            // two mix rounds, step_reg[0] marks the second
            ST_HMUL2:    state_next = step_reg[0] ? ST_HFIN : ST_HMUL1;
            ST_HFIN:     state_next = ST_MOD;
            ST_MOD:      if (step_reg == 7'd31) state_next = ST_MEMRD;
            ST_MEMRD:    state_next = ST_MEMWAIT;
            ST_MEMWAIT:  state_next = ST_MEMCHK;
            ST_MEMCHK:
            begin
                if ((req_reg == REQ_PROBE && !fm_rd) ||
                    ({1'b0, hidx_reg} + 4'd1 >= 4'(eff_hashes)))
                    state_next = ST_DIV;
                else
                    state_next = ST_HLOAD;
            end
            ST_RINGRD:   state_next = ST_RINGWAIT;
            ST_RINGWAIT: state_next = ST_RINGUPD;
            ST_RINGUPD:  state_next = ST_DIV;
            ST_DIV:      if (step_reg == 7'd64) state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            ST_CLEAR:
            begin
                if (sweep_end)
                    state_next = boot_reg ? ST_IDLE
                               : ((req_reg == REQ_CLEAR) ? ST_DIV : ST_IDLE);
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs / datapath control ----------------
    // the remainder stays in acc from the last mod step to the memory check
    always_comb
    begin
        op       = OP_NONE;
        load_val = 64'd0;
        divisor  = {{(64-CCW){1'b0}}, eff_cells};
        fm_we    = 1'b0;
        fm_wa    = acc[CW-1:0];
        fm_wd    = 1'b1;
        fm_ra    = acc[CW-1:0];
        rg_we    = 1'b0;
        rg_wa    = slot_reg;
        rg_ra    = slot_reg;
        rh_wd    = cur_hits_reg;
        rp_wd    = cur_probes_reg;
        unique case (state_reg)
            ST_HLOAD:
            begin
                op       = OP_XLOAD;
                load_val = {key_reg, 16'd0, seed};
            end
            ST_HMUL1:    op = OP_MIXLO;
            ST_HMUL2:    op = OP_MIXHI;
            ST_HFIN:     op = OP_FIN;
            ST_MOD:      op = OP_MODSTEP;
            ST_MEMRD:    fm_we = (req_reg == REQ_INSERT);
            ST_DIV:
            begin
                divisor = {28'd0, sum_probes_reg};
                if (step_reg == 7'd0)
                begin
                    op       = OP_LOAD;
                    load_val = {12'd0, sum_hits_reg, 16'd0};
                end
                else
                    op = OP_DIVSTEP;
            end
            ST_RINGUPD:  rg_we = 1'b1;
            ST_CLEAR:
            begin
                fm_we = boot_reg;
                fm_wd = 1'b0;
                fm_wa = sweep_reg[CW-1:0];
                rg_we = (sweep_reg < (CW+1)'(WD));
                rg_wa = sweep_reg[WW-1:0];
                rh_wd = 32'd0;
                rp_wd = 32'd0;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            boot_reg       <= 1'b1;
            sweep_reg      <= '0;
            step_reg       <= '0;
            hidx_reg       <= '0;
            key_reg        <= '0;
            cur_hits_reg   <= '0;
            cur_probes_reg <= '0;
            sum_hits_reg   <= '0;
            sum_probes_reg <= '0;
            slot_reg       <= WW'(WINDOW - 1);
            req_reg        <= REQ_INSERT;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (win_restart)
            begin
                sum_hits_reg   <= '0;
                sum_probes_reg <= '0;
                slot_reg       <= WW'(eff_win_cfg - LW'(1));
                req_reg        <= REQ_TICK;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    sweep_reg <= '0;
                    step_reg  <= '0;
                    hidx_reg  <= '0;
                    hit_reg   <= 1'b0;
                    if (start && !win_restart)
                    begin
                        req_reg <= req_t'(req.req_type);
                        key_reg <= req.key[31:0];
                        if (req.req_type == REQ_PROBE)
                        begin
                            if (cur_probes_reg != 32'hFFFF_FFFF)
                                cur_probes_reg <= cur_probes_reg + 32'd1;
                            if (eff_hashes == '0)
                            begin
                                hit_reg <= 1'b1;
                                if (cur_hits_reg != 32'hFFFF_FFFF)
                                    cur_hits_reg <= cur_hits_reg + 32'd1;
                            end
                        end
                        if (req.req_type == REQ_CLEAR)
                        begin
                            cur_hits_reg   <= '0;
                            cur_probes_reg <= '0;
                            sum_hits_reg   <= '0;
                            sum_probes_reg <= '0;
                        end
                    end
                end
                ST_HMUL2:   step_reg <= step_reg[0] ? 7'd0 : 7'd1;
                ST_MOD:     step_reg <= step_reg + 7'd1;
                ST_MEMRD:   step_reg <= '0;
                ST_MEMCHK:
                begin
                    hidx_reg <= hidx_reg + 3'd1;
                    if (req_reg == REQ_PROBE && state_next == ST_DIV && fm_rd)
                    begin
                        hit_reg <= 1'b1;
                        if (cur_hits_reg != 32'hFFFF_FFFF)
                            cur_hits_reg <= cur_hits_reg + 32'd1;
                    end
                end
                ST_RINGUPD:
                begin
                    sum_hits_reg <= ((sum_hits_reg >= {4'd0, rh_rd})
                                    ? sum_hits_reg - {4'd0, rh_rd} : 36'd0)
                                    + {4'd0, cur_hits_reg};
                    sum_probes_reg <= ((sum_probes_reg >= {4'd0, rp_rd})
                                    ? sum_probes_reg - {4'd0, rp_rd} : 36'd0)
                                    + {4'd0, cur_probes_reg};
                    slot_reg <= (slot_reg == '0) ? WW'(eff_win - LW'(1))
                                                 : slot_reg - WW'(1);
                    cur_hits_reg   <= '0;
                    cur_probes_reg <= '0;
                end
                ST_DIV:     step_reg <= step_reg + 7'd1;
                ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + (CW+1)'(1);
                    if (sweep_end)
                        boot_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // ---------------- result ----------------
    logic [16:0] rate;
    always_comb
    begin
        if (sum_probes_reg == 36'd0)
            rate = 17'd65536;
        else if (quo > 64'd65536)
            rate = 17'd65536;
        else
            rate = quo[16:0];
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    always_comb
    begin
        rsp.hit           = hit_reg;
        rsp.hit_rate      = rate;
        rsp.window_hits   = sum_hits_reg;
        rsp.window_probes = sum_probes_reg;
    end

    `BF_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `BF_ASSERT_NXT(a_done_idle, clk, rst_n, done, !busy)
    `BF_ASSERT_IMP(a_hit_probe, clk, rst_n, done && rsp.hit, req_reg == REQ_PROBE)
endmodule
